// ----- hdl/sfd_pkg.sv -----
// Shared types, constants and the CRC-8 byte update for the sensor frame decoder.
package sfd_pkg;

    // Command codes of an input beat.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_BYTE = 1'b1;

    // Byte positions inside a six-byte frame.
    localparam logic [2:0] BYTE_T_HI  = 3'd0;
    localparam logic [2:0] BYTE_T_LO  = 3'd1;
    localparam logic [2:0] BYTE_T_CRC = 3'd2;
    localparam logic [2:0] BYTE_H_HI  = 3'd3;
    localparam logic [2:0] BYTE_H_LO  = 3'd4;
    localparam logic [2:0] BYTE_H_CRC = 3'd5;
    localparam logic [2:0] BYTE_DONE  = 3'd6;

    // CRC-8 parameters.
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // Conversion constants.
    localparam int unsigned TEMP_SCALE  = 17500;
    localparam int unsigned TEMP_OFFSET = 4500;
    localparam int unsigned HUM_SCALE   = 100;
    localparam int unsigned MS_PER_S    = 1000;
    localparam int unsigned TENTHS_CENTI = 10;

    // Elapsed-time counter.
    localparam int unsigned ELAPSED_W   = 22;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 22'd3600000;

    // Widths of fields and scaled configuration values.
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 12;
    localparam int unsigned TEMP_W     = 15;
    localparam int unsigned HUM_W      = 7;
    localparam int unsigned TDELTA_W   = 12;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TEMP_CRC = 2'd1,
        ST_HUM_CRC  = 2'd2
    } t_status;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_INTERVAL = 2'd0,
        CFG_MAX_INTERVAL = 2'd1,
        CFG_HUM_DELTA    = 2'd2,
        CFG_TEMP_DELTA   = 2'd3
    } t_cfg_idx;

    // One input beat.
    typedef struct packed {
        logic       cmd;
        logic       frame_start;
        logic [7:0] rx_byte;
    } t_item;

    // Configuration, already scaled to the units that the filter compares in.
    typedef struct packed {
        logic [ELAPSED_W-1:0] min_ms;
        logic [ELAPSED_W-1:0] max_ms;
        logic [HUM_W-1:0]     hum_delta;
        logic [TDELTA_W-1:0]  temp_delta_centi;
    } t_cfg;

    // Frame decoder to report filter: what the last byte of a frame produced.
    typedef struct packed {
        logic             valid;
        t_status          status;
        logic             hum_ok;
        logic [HUM_W-1:0] hum_new;
    } t_frame_res;

    // One byte of CRC-8, MSB first, no reflection.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ----- hdl/sensor_frame_decode_and_report_filter_unit.sv -----
// Top level of the sensor frame decoder with report-on-change filter.
//
// Each input beat is either a one-millisecond tick or one byte of a six-byte
// frame (temperature word, CRC-8, humidity word, CRC-8; polynomial 0x31, init
// 0xFF). The block takes one beat per clock cycle when the result side keeps
// up: a beat is captured in an input register, and when it moves on its CRC
// byte update, word conversion and report decision run in one pass of logic
// into the result register. Only the sixth byte of a frame gives a result;
// ticks, other bytes and bytes past the end of a frame give none. The input
// stalls only while a result waits in the output register and the sink holds
// ready low. Configuration writes are taken at any time with ready held high
// and should be made while no frame is in flight; no clearing pass follows
// reset.
module sensor_frame_decode_and_report_filter_unit import sfd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input beats.
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_cmd,
    input  logic                  i_frame_start,
    input  logic [7:0]            i_rx_byte,
    // Result beats.
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [1:0]            o_status,
    output logic                  o_report,
    output logic signed [14:0]    o_temp_centi,
    output logic [6:0]            o_humidity_pct,
    // Configuration writes.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic                     r_in_valid;
    t_item                    r_in;
    logic                     r_out_valid;
    logic [1:0]               r_out_status;
    logic                     r_out_report;
    logic signed [TEMP_W-1:0] r_out_temp;
    logic [HUM_W-1:0]         r_out_hum;

    logic                     step;
    t_cfg                     cfg;
    t_frame_res               res;
    logic signed [TEMP_W-1:0] cur_temp;
    logic [HUM_W-1:0]         cur_hum;
    logic                     report;

    // The held beat moves on whenever the result register can take a result.
    assign step        = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready     = !r_in_valid || step;
    assign o_cfg_ready = 1'b1;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in.cmd         <= i_cmd;
            r_in.frame_start <= i_frame_start;
            r_in.rx_byte     <= i_rx_byte;
        end
    end

    sfd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sfd_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (step && (r_in.cmd == CMD_BYTE)),
        .i_item     (r_in),
        .o_res      (res),
        .o_cur_temp (cur_temp),
        .o_cur_hum  (cur_hum)
    );

    sfd_report_filter u_filter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tick     (step && (r_in.cmd == CMD_TICK)),
        .i_res      (res),
        .i_cur_temp (cur_temp),
        .i_cfg      (cfg),
        .o_report   (report)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_out_status <= res.status;
            r_out_report <= report;
            // The temperature register already holds the last temperature that passed its CRC check.
            r_out_temp   <= cur_temp;
            r_out_hum    <= res.hum_ok ? res.hum_new : cur_hum;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_report       = r_out_report;
    assign o_temp_centi   = r_out_temp;
    assign o_humidity_pct = r_out_hum;

endmodule

// ----- hdl/sfd_cfg_regs.sv -----
// Configuration registers, stored pre-scaled to milliseconds and centi-degrees.
module sfd_cfg_regs import sfd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Scale the written value on its way in.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MIN_INTERVAL: n_cfg.min_ms =
                    ELAPSED_W'(i_cfg_data) * ELAPSED_W'(MS_PER_S);
                CFG_MAX_INTERVAL: n_cfg.max_ms =
                    ELAPSED_W'(i_cfg_data) * ELAPSED_W'(MS_PER_S);
                CFG_HUM_DELTA:    n_cfg.hum_delta = i_cfg_data[HUM_W-1:0];
                CFG_TEMP_DELTA:   n_cfg.temp_delta_centi =
                    TDELTA_W'(i_cfg_data[7:0]) * TDELTA_W'(TENTHS_CENTI);
                default: n_cfg = r_cfg;
            endcase
        end
    end

    // Reset values are 10 s, 150 s, 2 percent and 0.5 degree.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_ms           <= ELAPSED_W'(10 * MS_PER_S);
            r_cfg.max_ms           <= ELAPSED_W'(150 * MS_PER_S);
            r_cfg.hum_delta        <= HUM_W'(2);
            r_cfg.temp_delta_centi <= TDELTA_W'(5 * TENTHS_CENTI);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hdl/sfd_decode.sv -----
// Frame byte tracking, CRC-8 checks and conversion of the two sensor words.
module sfd_decode import sfd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  t_item                    i_item,
    output t_frame_res               o_res,
    output logic signed [TEMP_W-1:0] o_cur_temp,
    output logic [HUM_W-1:0]         o_cur_hum
);

    logic [2:0]               r_idx, n_idx;
    logic [7:0]               r_crc, n_crc;
    logic [7:0]               r_word_hi, n_word_hi;
    logic [7:0]               r_word_lo, n_word_lo;
    logic                     r_temp_failed, n_temp_failed;
    logic signed [TEMP_W-1:0] r_cur_temp, n_cur_temp;
    logic [HUM_W-1:0]         r_cur_hum, n_cur_hum;

    logic [2:0]               eff_idx;
    logic [7:0]               eff_crc;
    logic                     eff_tf;
    logic [15:0]              raw;
    logic [30:0]              temp_prod;
    logic signed [15:0]       temp_conv;
    logic [22:0]              hum_prod;
    logic [7:0]               crc_next;

    // A frame start restarts the frame from its first byte.
    assign eff_idx  = i_item.frame_start ? BYTE_T_HI : r_idx;
    assign eff_crc  = i_item.frame_start ? CRC_INIT : r_crc;
    assign eff_tf   = i_item.frame_start ? 1'b0 : r_temp_failed;
    assign crc_next = crc8_step(eff_crc, i_item.rx_byte);

    // Word conversions: ((17500 * raw) >> 16) - 4500 and (100 * raw) >> 16.
    assign raw       = {r_word_hi, r_word_lo};
    assign temp_prod = 31'(raw) * 31'(TEMP_SCALE);
    assign temp_conv = $signed({1'b0, temp_prod[30:16]}) - 16'(TEMP_OFFSET);
    assign hum_prod  = 23'(raw) * 23'(HUM_SCALE);

    // Next state and frame result.
    always_comb begin
        n_idx         = r_idx;
        n_crc         = r_crc;
        n_word_hi     = r_word_hi;
        n_word_lo     = r_word_lo;
        n_temp_failed = r_temp_failed;
        n_cur_temp    = r_cur_temp;
        n_cur_hum     = r_cur_hum;
        o_res         = '0;
        o_res.status  = ST_OK;
        o_res.hum_new = hum_prod[22:16];
        if (i_en) begin
            n_idx         = eff_idx;
            n_crc         = eff_crc;
            n_temp_failed = eff_tf;
            case (eff_idx)
                BYTE_T_HI, BYTE_H_HI: begin
                    n_word_hi = i_item.rx_byte;
                    n_crc     = crc_next;
                    n_idx     = eff_idx + 3'd1;
                end
                BYTE_T_LO, BYTE_H_LO: begin
                    n_word_lo = i_item.rx_byte;
                    n_crc     = crc_next;
                    n_idx     = eff_idx + 3'd1;
                end
                BYTE_T_CRC: begin
                    if (eff_crc == i_item.rx_byte) begin
                        n_cur_temp    = temp_conv[TEMP_W-1:0];
                        n_temp_failed = 1'b0;
                    end else begin
                        n_temp_failed = 1'b1;
                    end
                    n_crc = CRC_INIT;
                    n_idx = BYTE_H_HI;
                end
                BYTE_H_CRC: begin
                    o_res.valid = 1'b1;
                    if (eff_tf) begin
                        o_res.status = ST_TEMP_CRC;
                    end else if (eff_crc != i_item.rx_byte) begin
                        o_res.status = ST_HUM_CRC;
                    end else begin
                        o_res.hum_ok = 1'b1;
                        n_cur_hum    = hum_prod[22:16];
                    end
                    n_crc = CRC_INIT;
                    n_idx = BYTE_DONE;
                end
                default: begin
                    // Bytes after the end of a frame are dropped.
                    n_idx = eff_idx;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx         <= BYTE_T_HI;
            r_crc         <= CRC_INIT;
            r_word_hi     <= '0;
            r_word_lo     <= '0;
            r_temp_failed <= 1'b0;
            r_cur_temp    <= '0;
            r_cur_hum     <= '0;
        end else begin
            r_idx         <= n_idx;
            r_crc         <= n_crc;
            r_word_hi     <= n_word_hi;
            r_word_lo     <= n_word_lo;
            r_temp_failed <= n_temp_failed;
            r_cur_temp    <= n_cur_temp;
            r_cur_hum     <= n_cur_hum;
        end
    end

    assign o_cur_temp = r_cur_temp;
    assign o_cur_hum  = r_cur_hum;

endmodule

// ----- hdl/sfd_report_filter.sv -----
// Report-on-change decision with the elapsed-time counter and last reported values.
module sfd_report_filter import sfd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_tick,
    input  t_frame_res               i_res,
    input  logic signed [TEMP_W-1:0] i_cur_temp,
    input  t_cfg                     i_cfg,
    output logic                     o_report
);

    logic [ELAPSED_W-1:0]     r_elapsed_ms, n_elapsed_ms;
    logic signed [TEMP_W-1:0] r_sent_temp, n_sent_temp;
    logic [HUM_W-1:0]         r_sent_hum, n_sent_hum;

    logic                     min_block;
    logic                     max_trig;
    logic                     hum_trig;
    logic                     temp_trig;
    logic [HUM_W-1:0]         hum_diff;
    logic signed [TEMP_W:0]   temp_diff;
    logic [TEMP_W:0]          temp_abs;
    logic                     report;

    // Interval checks against the scaled interval registers.
    assign min_block = (i_cfg.min_ms != '0) && (r_elapsed_ms < i_cfg.min_ms);
    assign max_trig  = (i_cfg.max_ms != '0) && (r_elapsed_ms >= i_cfg.max_ms);

    // Humidity change since the last report.
    assign hum_diff = (i_res.hum_new >= r_sent_hum) ? (i_res.hum_new - r_sent_hum)
                                                    : (r_sent_hum - i_res.hum_new);
    assign hum_trig = (i_cfg.hum_delta != '0) && (hum_diff >= i_cfg.hum_delta);

    // Temperature change since the last report.
    assign temp_diff = (TEMP_W+1)'(i_cur_temp) - (TEMP_W+1)'(r_sent_temp);
    assign temp_abs  = temp_diff[TEMP_W] ? (TEMP_W+1)'(-temp_diff) : (TEMP_W+1)'(temp_diff);
    assign temp_trig = (i_cfg.temp_delta_centi != '0) &&
                       (temp_abs >= (TEMP_W+1)'(i_cfg.temp_delta_centi));

    assign report   = i_res.valid && i_res.hum_ok && !min_block &&
                      (max_trig || hum_trig || temp_trig);
    assign o_report = report;

    // Counter and last reported values.
    always_comb begin
        n_elapsed_ms = r_elapsed_ms;
        n_sent_temp  = r_sent_temp;
        n_sent_hum   = r_sent_hum;
        if (i_tick && (r_elapsed_ms < ELAPSED_MAX)) begin
            n_elapsed_ms = r_elapsed_ms + ELAPSED_W'(1);
        end
        if (report) begin
            n_elapsed_ms = '0;
            n_sent_temp  = i_cur_temp;
            n_sent_hum   = i_res.hum_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed_ms <= '0;
            r_sent_temp  <= '0;
            r_sent_hum   <= '0;
        end else begin
            r_elapsed_ms <= n_elapsed_ms;
            r_sent_temp  <= n_sent_temp;
            r_sent_hum   <= n_sent_hum;
        end
    end

    // The counter never passes its saturation value.
    a_elapsed_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_elapsed_ms <= ELAPSED_MAX)
        else $error("elapsed counter above saturation value");

    // A report restarts the interval timer.
    a_report_clears_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        report |=> (r_elapsed_ms == '0))
        else $error("elapsed counter not cleared after report");

    // A report records the humidity and temperature it carried.
    a_report_records: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        report |=> (r_sent_hum == $past(i_res.hum_new)) &&
                   (r_sent_temp == $past(i_cur_temp)))
        else $error("last reported values not updated");

endmodule
